FILE: rtl/cfs_pkg.sv
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared constants and types of the capped flow sampler.
// ----------------------------------------------------------------------------
package cfs_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = TBL_AW + 1;
   localparam int HEADER_BYTES  = 96;
   localparam int PKT_CNT_W     = 16;

   localparam logic [15:0] LIMIT_RESET = 16'd10;
   localparam logic [15:0] LIMIT_CAP   = 16'd65534;
   localparam logic [15:0] ETH_IPV4    = 16'h0800;
   localparam logic [7:0]  PROTO_ICMP  = 8'd1;
   localparam logic [7:0]  PROTO_TCP   = 8'd6;
   localparam logic [7:0]  PROTO_UDP   = 8'd17;
   localparam logic        OP_BYTE     = 1'b0;
   localparam logic        OP_CLEAR    = 1'b1;

   // session key, as held in the table
   typedef struct packed {
      logic [31:0] lo_addr;
      logic [31:0] hi_addr;
      logic [15:0] lo_port;
      logic [15:0] hi_port;
      logic [7:0]  proto;
   } key_type;

   localparam int KEY_W   = $bits(key_type);
   localparam int ENTRY_W = KEY_W + PKT_CNT_W;

   // one feature record
   typedef struct packed {
      key_type     key;
      logic [15:0] total_length;
      logic [15:0] frag_word;
      logic [15:0] payload_length;
      logic [31:0] ack_number;
      logic [7:0]  flag_bits;
      logic [15:0] window;
      logic [7:0]  icmp_kind;
   } rec_type;

   // parser to table
   typedef struct packed {
      logic    frame_ok;
      rec_type rec;
   } frame_type;

endpackage

FILE: rtl/cfs_if.sv
// ----------------------------------------------------------------------------
// cfs channel interfaces
// Valid/ready channels for frame beats, records and the limit register.
// ----------------------------------------------------------------------------
interface cfs_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] frame_byte;
   logic       last_byte;
   modport source (output valid, op, frame_byte, last_byte, input ready);
   modport sink   (input valid, op, frame_byte, last_byte, output ready);
endinterface

interface cfs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] key_low_addr;
   logic [31:0] key_high_addr;
   logic [15:0] key_low_port;
   logic [15:0] key_high_port;
   logic [7:0]  ip_protocol;
   logic [15:0] ip_total_length;
   logic [15:0] ip_frag_word;
   logic [15:0] payload_length;
   logic [31:0] tcp_ack_number;
   logic [7:0]  tcp_flag_bits;
   logic [15:0] tcp_window;
   logic [7:0]  icmp_kind;
   modport source (output valid, key_low_addr, key_high_addr, key_low_port, key_high_port,
                   ip_protocol, ip_total_length, ip_frag_word, payload_length,
                   tcp_ack_number, tcp_flag_bits, tcp_window, icmp_kind, input ready);
   modport sink   (input valid, key_low_addr, key_high_addr, key_low_port, key_high_port,
                   ip_protocol, ip_total_length, ip_frag_word, payload_length,
                   tcp_ack_number, tcp_flag_bits, tcp_window, icmp_kind, output ready);
endinterface

interface cfs_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/cfs_ram.sv
// ----------------------------------------------------------------------------
// cfs_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/cfs_parse.sv
// ----------------------------------------------------------------------------
// cfs_parse
// Picks header fields out of the byte stream and checks the frame.
// ----------------------------------------------------------------------------
module cfs_parse (
   input  logic                clock,
   input  logic                byte_we,
   input  logic [15:0]         byte_pos,
   input  logic [7:0]          frame_byte,
   input  logic                last_byte,
   output cfs_pkg::frame_type  frame
);
   import cfs_pkg::*;

   logic [15:0] eth_type_ff;
   logic [7:0]  vih_ff;
   logic [15:0] tot_ff;
   logic [15:0] frag_ff;
   logic [7:0]  proto_ff;
   logic [31:0] saddr_ff;
   logic [31:0] daddr_ff;
   logic [15:0] sport_ff;
   logic [15:0] dport_ff;
   logic [15:0] ulen_ff;
   logic [31:0] ack_ff;
   logic [7:0]  flags_ff;
   logic [15:0] win_ff;
   logic [15:0] last_pos_ff;

   logic [3:0]  ihl_now;
   logic [15:0] l4_now;
   logic [15:0] rel;
   logic        in_l4;

   // transport offset, with the ihl of this beat when it arrives now
   assign ihl_now = (byte_pos == 16'd14) ? frame_byte[3:0] : vih_ff[3:0];
   assign l4_now  = 16'd14 + {10'd0, ihl_now, 2'b00};
   assign rel     = byte_pos - l4_now;
   assign in_l4   = (byte_pos >= l4_now) && (rel < 16'd20);

   // fixed-position capture
   always_ff @(posedge clock) begin
      if (byte_we && (byte_pos < 16'(HEADER_BYTES))) begin
         case (byte_pos)
            16'd12: eth_type_ff[15:8] <= frame_byte;
            16'd13: eth_type_ff[7:0]  <= frame_byte;
            16'd14: vih_ff            <= frame_byte;
            16'd16: tot_ff[15:8]      <= frame_byte;
            16'd17: tot_ff[7:0]       <= frame_byte;
            16'd20: frag_ff[15:8]     <= frame_byte;
            16'd21: frag_ff[7:0]      <= frame_byte;
            16'd23: proto_ff          <= frame_byte;
            16'd26: saddr_ff[31:24]   <= frame_byte;
            16'd27: saddr_ff[23:16]   <= frame_byte;
            16'd28: saddr_ff[15:8]    <= frame_byte;
            16'd29: saddr_ff[7:0]     <= frame_byte;
            16'd30: daddr_ff[31:24]   <= frame_byte;
            16'd31: daddr_ff[23:16]   <= frame_byte;
            16'd32: daddr_ff[15:8]    <= frame_byte;
            16'd33: daddr_ff[7:0]     <= frame_byte;
            default: ;
         endcase
      end
   end

   // transport header capture, relative to its start
   always_ff @(posedge clock) begin
      if (byte_we && in_l4) begin
         case (rel[4:0])
            5'd0:  sport_ff[15:8] <= frame_byte;
            5'd1:  sport_ff[7:0]  <= frame_byte;
            5'd2:  dport_ff[15:8] <= frame_byte;
            5'd3:  dport_ff[7:0]  <= frame_byte;
            5'd4:  ulen_ff[15:8]  <= frame_byte;
            5'd5:  ulen_ff[7:0]   <= frame_byte;
            5'd8:  ack_ff[31:24]  <= frame_byte;
            5'd9:  ack_ff[23:16]  <= frame_byte;
            5'd10: ack_ff[15:8]   <= frame_byte;
            5'd11: ack_ff[7:0]    <= frame_byte;
            5'd13: flags_ff       <= frame_byte;
            5'd14: win_ff[15:8]   <= frame_byte;
            5'd15: win_ff[7:0]    <= frame_byte;
            default: ;
         endcase
      end
      if (byte_we && last_byte) begin
         last_pos_ff <= byte_pos;
      end
   end

   logic        is_tcp, is_udp, is_icmp;
   logic [16:0] l4_end;
   logic        eth_ok, ip_ok, l4_ok;
   logic [15:0] ihl4;
   logic [15:0] sport_v, dport_v;

   // frame checks and record build
   always_comb begin
      is_tcp  = (proto_ff == PROTO_TCP);
      is_udp  = (proto_ff == PROTO_UDP);
      is_icmp = (proto_ff == PROTO_ICMP);
      ihl4    = {10'd0, vih_ff[3:0], 2'b00};
      l4_end  = 17'd14 + {1'b0, ihl4} + (is_tcp ? 17'd20 : 17'd8);
      eth_ok  = (last_pos_ff >= 16'd13) && (eth_type_ff == ETH_IPV4);
      ip_ok   = (last_pos_ff >= 16'd33) && (vih_ff[7:4] == 4'd4);
      l4_ok   = (l4_end <= ({1'b0, last_pos_ff} + 17'd1)) && (is_tcp || is_udp || is_icmp);
      frame.frame_ok = eth_ok && ip_ok && l4_ok;

      sport_v = is_icmp ? 16'd0 : sport_ff;
      dport_v = is_icmp ? 16'd0 : dport_ff;
      if (saddr_ff < daddr_ff) begin
         frame.rec.key.lo_addr = saddr_ff;
         frame.rec.key.hi_addr = daddr_ff;
         frame.rec.key.lo_port = sport_v;
         frame.rec.key.hi_port = dport_v;
      end else begin
         frame.rec.key.lo_addr = daddr_ff;
         frame.rec.key.hi_addr = saddr_ff;
         frame.rec.key.lo_port = dport_v;
         frame.rec.key.hi_port = sport_v;
      end
      frame.rec.key.proto    = proto_ff;
      frame.rec.total_length = tot_ff;
      frame.rec.frag_word    = frag_ff;
      if (is_tcp) begin
         frame.rec.payload_length = tot_ff - ihl4 - 16'd20;
      end else if (is_udp) begin
         frame.rec.payload_length = ulen_ff - 16'd8;
      end else begin
         frame.rec.payload_length = 16'd0;
      end
      frame.rec.ack_number = is_tcp ? ack_ff : 32'd0;
      frame.rec.flag_bits  = is_tcp ? flags_ff : 8'd0;
      frame.rec.window     = is_tcp ? win_ff : 16'd0;
      frame.rec.icmp_kind  = is_icmp ? sport_ff[15:8] : 8'd0;
   end

endmodule

FILE: rtl/cfs_table.sv
// ----------------------------------------------------------------------------
// cfs_table
// Session table: linear search over the filled entries, insert, count update.
// ----------------------------------------------------------------------------
module cfs_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               clear,
   input  cfs_pkg::key_type   key,
   input  logic [15:0]        limit,
   input  logic               emit_ready,
   output logic               emit_valid,
   output logic               idle
);
   import cfs_pkg::*;

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_READ = 2'd1;
   localparam logic [1:0] T_CMP  = 2'd2;
   localparam logic [1:0] T_EMIT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] idx_ff, idx_in;

   logic               wr_en;
   logic [TBL_AW-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;
   logic [PKT_CNT_W-1:0] cnt_old, cnt_new;
   logic [15:0]        lim;

   cfs_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff[TBL_AW-1:0]),
      .rd_data (rd_data)
   );

   assign lim     = (limit > LIMIT_CAP) ? LIMIT_CAP : limit;
   assign cnt_old = rd_data[PKT_CNT_W-1:0];
   assign cnt_new = (cnt_old <= lim) ? cnt_old + 1'b1 : cnt_old;

   // search sequencer
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff[TBL_AW-1:0];
      wr_data  = {key, cnt_new};
      unique case (state_ff)
         T_IDLE: begin
            idx_in = '0;
            if (clear) begin
               fill_in = '0;
            end else if (start) begin
               state_in = T_READ;
            end
         end
         T_READ: begin
            if (idx_ff == fill_ff) begin
               // new session: lowest free entry, or drop when full
               if (fill_ff == CNT_W'(TABLE_ENTRIES)) begin
                  state_in = T_IDLE;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = fill_ff[TBL_AW-1:0];
                  wr_data  = {key, PKT_CNT_W'(1)};
                  fill_in  = fill_ff + 1'b1;
                  state_in = (lim >= 16'd1) ? T_EMIT : T_IDLE;
               end
            end else begin
               state_in = T_CMP;
            end
         end
         T_CMP: begin
            if (rd_data[ENTRY_W-1:PKT_CNT_W] == key) begin
               wr_en    = 1'b1;
               state_in = (cnt_new <= lim) ? T_EMIT : T_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = T_READ;
            end
         end
         T_EMIT: begin
            if (emit_ready) begin
               state_in = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         fill_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         idx_ff   <= idx_in;
      end
   end

   assign emit_valid = (state_ff == T_EMIT);
   assign idle       = (state_ff == T_IDLE);

endmodule

FILE: rtl/capped_flow_sampler_top.sv
// ----------------------------------------------------------------------------
// capped_flow_sampler_top
// Per-session sampler of IPv4 TCP/UDP/ICMP frames with a capped record count.
// ----------------------------------------------------------------------------
// frame bytes and clears: one beat per cycle while no frame check, lookup or emit runs
// frame end: a check step on the pending flag, then T_READ and T_CMP per table entry
//   searched (registered read of the session RAM), T_READ also inserts a new session,
//   then T_EMIT hands the record to the result register; input stalls meanwhile
// reset: empty table through the fill count, limit 10; RAM needs no clearing
module capped_flow_sampler_top (
   input  logic   clock,
   input  logic   reset,
   cfs_req_if.sink   req_ch,
   cfs_rsp_if.source rsp_ch,
   cfs_csr_if.sink   csr_ch
);
   import cfs_pkg::*;

   logic [15:0]  pos_ff;
   logic [15:0]  limit_ff;
   logic         pending_ff;
   logic         rsp_valid_ff;
   rec_type      rsp_rec_ff;
   frame_type    frame;
   logic         tbl_idle, emit_valid, emit_ready;
   logic         req_fire, byte_we, clear_fire;

   assign req_ch.ready = tbl_idle && !pending_ff;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign byte_we      = req_fire && (req_ch.op == OP_BYTE);
   assign clear_fire   = req_fire && (req_ch.op == OP_CLEAR);
   assign csr_ch.ready = 1'b1;

   // byte position and frame-end flag
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         pending_ff <= 1'b0;
         limit_ff   <= LIMIT_RESET;
      end else begin
         pending_ff <= byte_we && req_ch.last_byte;
         if (byte_we) begin
            if (req_ch.last_byte) begin
               pos_ff <= '0;
            end else if (pos_ff != 16'hFFFF) begin
               pos_ff <= pos_ff + 16'd1;
            end
         end
         if (csr_ch.valid) begin
            limit_ff <= csr_ch.data;
         end
      end
   end

   cfs_parse u_parse (
      .clock      (clock),
      .byte_we    (byte_we),
      .byte_pos   (pos_ff),
      .frame_byte (req_ch.frame_byte),
      .last_byte  (req_ch.last_byte),
      .frame      (frame)
   );

   assign emit_ready = !rsp_valid_ff || rsp_ch.ready;

   cfs_table u_table (
      .clock      (clock),
      .reset      (reset),
      .start      (pending_ff && frame.frame_ok),
      .clear      (clear_fire),
      .key        (frame.rec.key),
      .limit      (limit_ff),
      .emit_ready (emit_ready),
      .emit_valid (emit_valid),
      .idle       (tbl_idle)
   );

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_ready) begin
         rsp_valid_ff <= emit_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_ready && emit_valid) begin
         rsp_rec_ff <= frame.rec;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.key_low_addr    = rsp_rec_ff.key.lo_addr;
   assign rsp_ch.key_high_addr   = rsp_rec_ff.key.hi_addr;
   assign rsp_ch.key_low_port    = rsp_rec_ff.key.lo_port;
   assign rsp_ch.key_high_port   = rsp_rec_ff.key.hi_port;
   assign rsp_ch.ip_protocol     = rsp_rec_ff.key.proto;
   assign rsp_ch.ip_total_length = rsp_rec_ff.total_length;
   assign rsp_ch.ip_frag_word    = rsp_rec_ff.frag_word;
   assign rsp_ch.payload_length  = rsp_rec_ff.payload_length;
   assign rsp_ch.tcp_ack_number  = rsp_rec_ff.ack_number;
   assign rsp_ch.tcp_flag_bits   = rsp_rec_ff.flag_bits;
   assign rsp_ch.tcp_window      = rsp_rec_ff.window;
   assign rsp_ch.icmp_kind       = rsp_rec_ff.icmp_kind;

endmodule
